// ===== sv/bge_pkg.sv =====
// Shared constants, types and codes of the battery gauge estimator.
`timescale 1ns / 1ps
`default_nettype none

package bge_pkg;

    // Averaging window.
    localparam int WINDOW_DEPTH = 10;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    // Field widths.
    localparam int PCT_W  = 7;
    localparam int VOLT_W = 13;
    localparam int CUR_W  = 14;
    localparam int CAP_W  = 16;
    localparam int MIN_W  = 16;
    localparam int SUM_W  = CUR_W + $clog2(WINDOW_DEPTH);

    // Window mean by reciprocal multiply: exact for any window sum magnitude.
    localparam int AVG_SHIFT = CUR_W - 1 + 2 * PTR_W;
    localparam int AVG_RECIP = (2 ** AVG_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int PROD_W    = SUM_W + AVG_SHIFT;

    // Stream payload widths, packed and padded to whole bytes.
    localparam int IN_BITS  = PCT_W + VOLT_W + CUR_W + 1;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + 2 + 3 + MIN_W + CUR_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Estimate arithmetic.
    localparam int PERCENT_FULL  = 100;
    localparam int MIN_PER_HOUR  = 60;
    localparam int PU60_W        = PCT_W + 6;
    localparam int NUM_W         = PU60_W + CAP_W;
    localparam int DEN_W         = CUR_W + 7;
    localparam int ICON_HIGH_PCT = 75;
    localparam int ICON_MID_PCT  = 50;
    localparam int ICON_LOW_PCT  = 25;

    // Configuration registers.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CAP_W-1:0]     CAP_RESET     = 16'd500;
    localparam logic [VOLT_W-1:0]    THR_RESET     = 13'd2500;

    // Status codes.
    localparam logic [1:0] STATUS_ABSENT      = 2'd0;
    localparam logic [1:0] STATUS_FULL        = 2'd1;
    localparam logic [1:0] STATUS_CHARGING    = 2'd2;
    localparam logic [1:0] STATUS_DISCHARGING = 2'd3;

    // Icon codes.
    localparam logic [2:0] ICON_ABSENT   = 3'd0;
    localparam logic [2:0] ICON_CHARGING = 3'd1;
    localparam logic [2:0] ICON_HIGH     = 3'd2;
    localparam logic [2:0] ICON_MID      = 3'd3;
    localparam logic [2:0] ICON_LOW      = 3'd4;
    localparam logic [2:0] ICON_EMPTY    = 3'd5;

    // Ring memory access.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [PTR_W-1:0] addr;
        logic [CUR_W-1:0] wr_data;
    } ring_req_t;

    // Divider request.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// ===== sv/bge_ring_mem.sv =====
// Current ring: synchronous memory with per-entry valid bits that reset clears.
`timescale 1ns / 1ps
`default_nettype none

module bge_ring_mem (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bge_pkg::ring_req_t       req,
    output logic [bge_pkg::CUR_W-1:0]     rd_data
);
    import bge_pkg::*;

    logic [CUR_W-1:0]        mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [CUR_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    // Unwritten entries read as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== sv/bge_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bge_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bge_pkg::div_req_t        req,
    output logic                          done,
    output logic [bge_pkg::NUM_W-1:0]     quotient
);
    import bge_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign rem_shift = {rem_reg, q_reg[NUM_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign fits      = !diff[DEN_W];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== sv/battery_gauge_estimator_unit.sv =====
// Top level of the battery gauge estimator: control sequencer, config and output register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one gauge reading per request and returns one result: presence, status, icon,
// the ring-averaged current and minutes to full or empty. Readings are handled one at a
// time: the next request can be taken as soon as the result is loaded into the output
// register. The work is a ring memory read-modify-write, a reciprocal multiply for the
// window mean, then, when a time estimate is given, the serial divider runs NUM_W steps
// for the minutes estimate. While the result output stalls, a new result waits in the
// done state and no request is taken. The ring needs no clearing pass after reset. A
// finished result waits in the output register while the next reading is taken.
module battery_gauge_estimator_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // charge_percent[6:0], voltage_mv[19:7], current[33:20], is_charging[34]
    input  wire logic [bge_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // battery_present[0], status_code[2:1], icon_code[5:3], minutes_left[21:6],
    // avg_current[35:22]
    output logic [bge_pkg::OUT_W-1:0]         m_axis_tdata,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bge_pkg::CFG_W-1:0]    cfg_data
);
    import bge_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_READ     = 3'd1;
    localparam logic [2:0] ST_AVG      = 3'd2;
    localparam logic [2:0] ST_AVG_SIGN = 3'd3;
    localparam logic [2:0] ST_MUL      = 3'd4;
    localparam logic [2:0] ST_EST      = 3'd5;
    localparam logic [2:0] ST_EST_WAIT = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [PTR_W-1:0]        ptr_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CAP_W-1:0]        capacity_reg;
    logic [VOLT_W-1:0]       threshold_reg;

    logic [PCT_W-1:0]        pct_reg;
    logic [VOLT_W-1:0]       volt_reg;
    logic signed [CUR_W-1:0] cur_reg;
    logic                    chg_reg;

    logic                    present_reg;
    logic [1:0]              status_reg;
    logic [2:0]              icon_reg;
    logic [PU60_W-1:0]       pu60_reg;
    logic [CUR_W-1:0]        avg_mag_reg;
    logic signed [CUR_W-1:0] avg_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    est_en_reg;
    logic [MIN_W-1:0]        minutes_reg;

    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;

    ring_req_t               ring_req;
    logic [CUR_W-1:0]        ring_rd_data;
    div_req_t                div_req;
    logic                    div_done;
    logic [NUM_W-1:0]        div_q;

    logic                    in_accept;
    logic                    out_load;
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]        sum_abs;
    logic [PROD_W-1:0]       avg_prod;
    logic                    present_c;
    logic [1:0]              status_c;
    logic [2:0]              icon_c;
    logic [PCT_W-1:0]        pct_units;
    logic signed [CUR_W-1:0] avg_c;
    logic [CUR_W-1:0]        mag_c;
    logic                    est_en_c;

    bge_ring_mem u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    bge_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    // Ring access: read the oldest slot on accept, overwrite it in the next cycle.
    always_comb
    begin
        ring_req.rd_en   = in_accept;
        ring_req.wr_en   = (state_reg == ST_READ);
        ring_req.addr    = ptr_reg;
        ring_req.wr_data = cur_reg;
    end

    assign sum_new = sum_reg - SUM_W'(signed'(ring_rd_data)) + SUM_W'(cur_reg);
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // Divide the window magnitude by the depth; truncation toward zero follows.
    assign avg_prod = PROD_W'(sum_abs) * PROD_W'(AVG_RECIP);

    always_comb
    begin
        present_c = (volt_reg > threshold_reg);
        if (!present_c)
        begin
            status_c = STATUS_ABSENT;
            icon_c   = ICON_ABSENT;
        end
        else if (chg_reg)
        begin
            status_c = (pct_reg >= PCT_W'(PERCENT_FULL)) ? STATUS_FULL : STATUS_CHARGING;
            icon_c   = ICON_CHARGING;
        end
        else
        begin
            status_c = STATUS_DISCHARGING;
            if (pct_reg > PCT_W'(ICON_HIGH_PCT))
            begin
                icon_c = ICON_HIGH;
            end
            else if (pct_reg > PCT_W'(ICON_MID_PCT))
            begin
                icon_c = ICON_MID;
            end
            else if (pct_reg > PCT_W'(ICON_LOW_PCT))
            begin
                icon_c = ICON_LOW;
            end
            else
            begin
                icon_c = ICON_EMPTY;
            end
        end
        // Charge still to go when charging, charge left otherwise.
        if (chg_reg)
        begin
            pct_units = (pct_reg >= PCT_W'(PERCENT_FULL)) ? '0
                      : PCT_W'(PERCENT_FULL) - pct_reg;
        end
        else
        begin
            pct_units = pct_reg;
        end
    end

    always_comb
    begin
        avg_c    = sum_reg[SUM_W-1] ? -avg_mag_reg : avg_mag_reg;
        mag_c    = avg_reg[CUR_W-1] ? CUR_W'(-avg_reg) : CUR_W'(avg_reg);
        est_en_c = present_reg && (avg_reg != '0)
                && ((chg_reg && !avg_reg[CUR_W-1]) || (!chg_reg && avg_reg[CUR_W-1]));
    end

    always_comb
    begin
        div_req.start    = (state_reg == ST_EST) && est_en_reg;
        div_req.dividend = num_reg;
        div_req.divisor  = den_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     state_next = in_accept ? ST_READ : ST_IDLE;
            ST_READ:     state_next = ST_AVG;
            ST_AVG:      state_next = ST_AVG_SIGN;
            ST_AVG_SIGN: state_next = ST_MUL;
            ST_MUL:      state_next = ST_EST;
            ST_EST:      state_next = est_en_reg ? ST_EST_WAIT : ST_DONE;
            ST_EST_WAIT: state_next = div_done ? ST_DONE : ST_EST_WAIT;
            ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            capacity_reg  <= CAP_RESET;
            threshold_reg <= THR_RESET;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY:  capacity_reg  <= cfg_data[CAP_W-1:0];
                    CFG_THRESHOLD: threshold_reg <= cfg_data[VOLT_W-1:0];
                    default:       ;
                endcase
            end
            if (state_reg == ST_READ)
            begin
                sum_reg <= sum_new;
                ptr_reg <= (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pct_reg  <= s_axis_tdata[PCT_W-1:0];
            volt_reg <= s_axis_tdata[PCT_W +: VOLT_W];
            cur_reg  <= s_axis_tdata[PCT_W + VOLT_W +: CUR_W];
            chg_reg  <= s_axis_tdata[PCT_W + VOLT_W + CUR_W];
        end
        if (state_reg == ST_READ)
        begin
            present_reg <= present_c;
            status_reg  <= status_c;
            icon_reg    <= icon_c;
            pu60_reg    <= PU60_W'(pct_units) * PU60_W'(MIN_PER_HOUR);
        end
        if (state_reg == ST_AVG)
        begin
            avg_mag_reg <= avg_prod[AVG_SHIFT +: CUR_W];
        end
        if (state_reg == ST_AVG_SIGN)
        begin
            avg_reg <= avg_c;
        end
        if (state_reg == ST_MUL)
        begin
            num_reg    <= NUM_W'(pu60_reg) * NUM_W'(capacity_reg);
            den_reg    <= DEN_W'(mag_c) * DEN_W'(PERCENT_FULL);
            est_en_reg <= est_en_c;
        end
        if ((state_reg == ST_EST) && !est_en_reg)
        begin
            minutes_reg <= '0;
        end
        else if ((state_reg == ST_EST_WAIT) && div_done)
        begin
            // Saturate the estimate.
            minutes_reg <= (|div_q[NUM_W-1:MIN_W]) ? '1 : div_q[MIN_W-1:0];
        end
        if (out_load)
        begin
            m_data_reg <= OUT_W'({avg_reg, minutes_reg, icon_reg, status_reg, present_reg});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/bge_checker.sv =====
// Port-level assertions for the battery gauge estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bge_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [bge_pkg::OUT_W-1:0]     m_axis_tdata
);
    import bge_pkg::*;

    logic       present;
    logic [1:0] status;
    logic [2:0] icon;
    logic [MIN_W-1:0] minutes;
    logic [CUR_W-1:0] avg;

    assign present = m_axis_tdata[0];
    assign status  = m_axis_tdata[2:1];
    assign icon    = m_axis_tdata[5:3];
    assign minutes = m_axis_tdata[21:6];
    assign avg     = m_axis_tdata[35:22];

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One request at a time: no new request right after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in work");

    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !present |->
            status == STATUS_ABSENT && icon == ICON_ABSENT && minutes == '0)
        else $error("absent battery with nonzero status, icon or minutes");

    a_status_icon: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == STATUS_FULL || status == STATUS_CHARGING) |->
            icon == ICON_CHARGING)
        else $error("charging status without charging icon");

    a_minutes_avg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && minutes != '0 |-> avg != '0)
        else $error("estimate given with zero average current");

endmodule

bind battery_gauge_estimator_unit bge_checker u_bge_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_battery_gauge_estimator_unit.sv =====
// Testbench of the battery gauge estimator: stream driver, report checker and config sequence.
`timescale 1ns / 1ps

module tb_battery_gauge_estimator_unit;

    import bge_pkg::*;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  END_WAIT       = 100;
    localparam int  MINUTES_MAX    = 2 ** MIN_W - 1;

    // Packed so that the last field sits in the lowest bits.
    typedef struct packed {
        logic                    is_charging;
        logic signed [CUR_W-1:0] load_current;
        logic [VOLT_W-1:0]       voltage_mv;
        logic [PCT_W-1:0]        charge_percent;
    } reading_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] avg_current;
        logic [MIN_W-1:0]        minutes_left;
        logic [2:0]              icon_code;
        logic [1:0]              status_code;
        logic                    battery_present;
    } report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
    logic [CFG_W-1:0]     cfg_data = '0;

    battery_gauge_estimator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the block's registers and averaging window.
    logic [CAP_W-1:0]  capacity_shadow  = CAP_RESET;
    logic [VOLT_W-1:0] threshold_shadow = THR_RESET;
    int                window_ring [WINDOW_DEPTH] = '{default: 0};
    int                window_slot  = 0;
    int                window_total = 0;

    reading_t pending_readings [$];
    report_t  predicted_reports [$];

    int  send_idle_pct = 36;
    int  recv_idle_pct = 72;
    bit  drain_hold    = 1'b0;
    int  readings_issued  = 0;
    int  readings_taken   = 0;
    int  reports_seen     = 0;
    int  register_writes  = 0;
    int  mismatches       = 0;
    int  saturated_count  = 0;
    int  absent_count     = 0;
    int  full_count       = 0;
    int  estimate_count   = 0;
    int  stall_cycles     = 0;

    function automatic report_t compute_report(input reading_t r);
        report_t rep;
        int      avg;
        longint  units;
        longint  mag;
        longint  q;
        logic    present;
        begin
            window_total = window_total - window_ring[window_slot]
                         + int'($signed(r.load_current));
            window_ring[window_slot] = int'($signed(r.load_current));
            window_slot = (window_slot + 1 == WINDOW_DEPTH) ? 0 : window_slot + 1;
            avg = window_total / WINDOW_DEPTH;

            present = r.voltage_mv > threshold_shadow;

            if (!present)
                rep.status_code = STATUS_ABSENT;
            else if (r.is_charging)
                rep.status_code = (r.charge_percent >= PERCENT_FULL) ? STATUS_FULL
                                                                     : STATUS_CHARGING;
            else
                rep.status_code = STATUS_DISCHARGING;

            if (!present)
                rep.icon_code = ICON_ABSENT;
            else if (r.is_charging)
                rep.icon_code = ICON_CHARGING;
            else if (r.charge_percent > ICON_HIGH_PCT)
                rep.icon_code = ICON_HIGH;
            else if (r.charge_percent > ICON_MID_PCT)
                rep.icon_code = ICON_MID;
            else if (r.charge_percent > ICON_LOW_PCT)
                rep.icon_code = ICON_LOW;
            else
                rep.icon_code = ICON_EMPTY;

            // Estimate only when the sign of the average fits the mode.
            mag = 0;
            units = 0;
            if (present && r.is_charging && avg > 0)
            begin
                units = (r.charge_percent >= PERCENT_FULL) ? 0 : PERCENT_FULL - r.charge_percent;
                mag = avg;
            end
            else if (present && !r.is_charging && avg < 0)
            begin
                units = r.charge_percent;
                mag = -avg;
            end
            q = 0;
            if (mag != 0)
            begin
                q = (units * capacity_shadow * MIN_PER_HOUR) / (PERCENT_FULL * mag);
                estimate_count++;
                if (q > MINUTES_MAX)
                begin
                    q = MINUTES_MAX;
                    saturated_count++;
                end
            end

            if (!present)
                absent_count++;
            if (rep.status_code == STATUS_FULL)
                full_count++;

            rep.battery_present = present;
            rep.minutes_left    = q[MIN_W-1:0];
            rep.avg_current     = avg[CUR_W-1:0];
            return rep;
        end
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        begin
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        end
    endtask

    task automatic push_reading(input int pct, input int volt, input int cur, input bit chg);
        reading_t r;
        begin
            r.charge_percent = pct[PCT_W-1:0];
            r.voltage_mv     = volt[VOLT_W-1:0];
            r.load_current   = cur[CUR_W-1:0];
            r.is_charging    = chg;
            pending_readings.push_back(r);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            case (idx)
                CFG_CAPACITY:  capacity_shadow  = value[CAP_W-1:0];
                CFG_THRESHOLD: threshold_shadow = value[VOLT_W-1:0];
                default: ;
            endcase
            register_writes++;
        end
    endtask

    // Hold until every queued reading has gone in and every report has come back.
    task automatic wait_drained;
        begin
            do
                @(posedge clk);
            while (pending_readings.size() != 0 || readings_issued != reports_seen);
        end
    endtask

    // Reading driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_reports.push_back(compute_report(s_axis_tdata[IN_BITS-1:0]));
                readings_taken++;
            end
            if (drain_hold && !s_axis_tvalid && predicted_reports.size() == 0)
                drain_hold = 1'b0;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_readings.size() != 0 && !drain_hold
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata  <= IN_W'(pending_readings.pop_front());
                    s_axis_tvalid <= 1'b1;
                    readings_issued++;
                    // Pause the sender now and then until all reports are back.
                    if (readings_issued == 200 || $urandom_range(79) == 0)
                        drain_hold = 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Report monitor.
    always @(posedge clk)
    begin : report_monitor
        report_t got;
        report_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[OUT_BITS-1:0];
                reports_seen++;
                if (predicted_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: report with none predicted, expected nothing, actual %h",
                             $time, got);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    check_field("battery_present", want.battery_present, got.battery_present);
                    check_field("status_code", want.status_code, got.status_code);
                    check_field("icon_code", want.icon_code, got.icon_code);
                    check_field("minutes_left", want.minutes_left, got.minutes_left);
                    check_field("avg_current", $signed(want.avg_current),
                                $signed(got.avg_current));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)
            && !(cfg_valid && cfg_ready))
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, stall_cycles);
                $display("battery_gauge_estimator_unit verification failed");
                $finish;
            end
        end
        else
        begin
            stall_cycles = 0;
        end
    end

    initial
    begin
        int         ph;
        int         n;
        int         n_items;
        int         regime;
        int         regime_left;
        int         pct;
        int         volt;
        int         cur;
        bit         chg;
        logic [VOLT_W-1:0] thr;

        regime = 0;
        regime_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed readings at the reset register values.
        push_reading(0, 0, 0, 0);
        push_reading(100, 2500, 8191, 1);
        push_reading(0, 2501, 8191, 1);
        push_reading(99, 8191, 8191, 1);
        push_reading(100, 8191, 8191, 1);
        push_reading(127, 8191, 8191, 1);
        push_reading(50, 6000, 8191, 0);
        push_reading(127, 7000, -8192, 0);
        push_reading(100, 7000, -8192, 0);
        push_reading(76, 7000, -8192, 0);
        push_reading(75, 7000, -8192, 0);
        push_reading(51, 7000, -8192, 0);
        push_reading(50, 7000, -8192, 0);
        push_reading(26, 7000, -8192, 0);
        push_reading(25, 7000, -8192, 0);
        push_reading(1, 7000, -8192, 0);
        push_reading(0, 7000, -8192, 0);
        push_reading(60, 3000, -1, 1);
        push_reading(127, 3000, -8192, 1);
        push_reading(30, 4000, 8191, 0);
        wait_drained();

        for (ph = 0; ph < 9; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 72;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            thr = VOLT_W'($urandom_range(6000, 1500));
            n_items = 105;
            case (ph)
                0:
                begin
                    write_register(CFG_CAPACITY, 16'hFFFF);
                    write_register(CFG_THRESHOLD, 16'h0000);
                end
                1:
                begin
                    write_register(CFG_CAPACITY, 16'd1);
                    write_register(CFG_THRESHOLD, {3'($urandom), thr});
                end
                2:
                begin
                    // Top threshold: no reading can count as present.
                    write_register(CFG_CAPACITY, CFG_W'($urandom));
                    write_register(CFG_THRESHOLD, 16'h1FFF);
                    n_items = 40;
                end
                3:
                begin
                    write_register(CFG_CAPACITY, 16'd0);
                    write_register(CFG_THRESHOLD, {3'($urandom), thr});
                end
                4:
                begin
                    write_register(CFG_CAPACITY, CFG_W'($urandom));
                    write_register(CFG_THRESHOLD, {3'($urandom), thr});
                    // Unmapped indexes must leave both registers alone.
                    write_register(CFG_IDX_W'(2), CFG_W'($urandom));
                    write_register(CFG_IDX_W'(3), CFG_W'($urandom));
                end
                5:
                begin
                    write_register(CFG_CAPACITY, CAP_RESET);
                    write_register(CFG_THRESHOLD, CFG_W'(THR_RESET));
                end
                6:
                begin
                    write_register(CFG_CAPACITY, 16'hFFFF);
                    write_register(CFG_THRESHOLD, {3'($urandom), thr});
                end
                7:
                begin
                    write_register(CFG_CAPACITY, CFG_W'($urandom));
                    write_register(CFG_THRESHOLD, 16'hE000);
                end
                default:
                begin
                    write_register(CFG_CAPACITY, CFG_W'($urandom_range(4000, 1)));
                    write_register(CFG_THRESHOLD, {3'($urandom), thr});
                end
            endcase

            for (n = 0; n < n_items; n++)
            begin
                // Stay in one load profile for a stretch so the window average settles.
                if (regime_left == 0)
                begin
                    regime = $urandom_range(9);
                    regime_left = $urandom_range(20, 8);
                end
                regime_left--;

                pct = ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
                if ($urandom_range(99) < 85 && threshold_shadow < 8191)
                    volt = $urandom_range(8191, threshold_shadow + 1);
                else
                    volt = $urandom_range(8191);

                case (regime)
                    0, 1, 2:
                    begin
                        chg = ($urandom_range(9) != 0);
                        cur = $urandom_range(($urandom_range(1) != 0) ? 200 : 8191, 1);
                    end
                    3, 4, 5:
                    begin
                        chg = ($urandom_range(9) == 0);
                        cur = -$urandom_range(($urandom_range(1) != 0) ? 200 : 8192, 1);
                    end
                    6, 7:
                    begin
                        chg = $urandom_range(1);
                        cur = $urandom_range(60) - 30;
                    end
                    8:
                    begin
                        chg = $urandom_range(1);
                        cur = ($urandom_range(1) != 0) ? 8191 : -8192;
                    end
                    default:
                    begin
                        pct  = $urandom_range(127);
                        volt = $urandom_range(8191);
                        cur  = $urandom_range(16383) - 8192;
                        chg  = $urandom_range(1);
                    end
                endcase
                push_reading(pct, volt, cur, chg);
            end
            wait_drained();
        end

        repeat (END_WAIT) @(posedge clk);
        if (predicted_reports.size() != 0)
        begin
            mismatches++;
            $display("%0t: reports missing, expected %0d more, actual 0",
                     $time, predicted_reports.size());
        end

        $display("Ran %0d readings and %0d reports over %0d register writes, three idle mixes.",
                 readings_taken, reports_seen, register_writes);
        $display("Estimates %0d (saturated %0d), absent %0d, full %0d, mismatches %0d.",
                 estimate_count, saturated_count, absent_count, full_count, mismatches);
        if (mismatches == 0)
            $display("battery_gauge_estimator_unit verification clean");
        else
            $display("battery_gauge_estimator_unit verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bge_pkg.sv
sv/bge_ring_mem.sv
sv/bge_div.sv
sv/battery_gauge_estimator_unit.sv
sv/bge_checker.sv
tb/tb_battery_gauge_estimator_unit.sv
